### rtl/dnsopt_pkg.sv
`timescale 1ns / 1ps

package dnsopt_pkg;

  localparam int unsigned MAX_LABEL_BYTES = 63;
  localparam int unsigned MAX_NAME_BYTES  = 255;

  localparam logic [1:0] PtrBits   = 2'b11;
  localparam int unsigned FixedBytes  = 10;
  localparam int unsigned MinBody     = 5;
  localparam int unsigned HeaderBytes = 12;
  localparam logic [15:0] ClassIn = 16'd1;
  localparam logic [15:0] TypeOpt = 16'd41;

  localparam logic [1:0] VerdictParsed    = 2'd0;
  localparam logic [1:0] VerdictOpt       = 2'd1;
  localparam logic [1:0] VerdictUnsupport = 2'd2;
  localparam logic [1:0] VerdictMalformed = 2'd3;

  localparam logic [2:0] ReasonNone      = 3'd0;
  localparam logic [2:0] ReasonShort     = 3'd1;
  localparam logic [2:0] ReasonNameLen   = 3'd2;
  localparam logic [2:0] ReasonOpcode    = 3'd3;
  localparam logic [2:0] ReasonQdCount   = 3'd4;
  localparam logic [2:0] ReasonDirection = 3'd5;
  localparam logic [2:0] ReasonClass     = 3'd6;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] message_length;
    logic        direction;
    logic        last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [2:0]  reason;
    logic [15:0] record_offset;
  } out_t;

endpackage

### rtl/dns_message_opt_record_locator_unit.sv
`timescale 1ns / 1ps

// DNS OPT record locator. Feed a DNS message one byte per request, header first, with the
// declared length and the direction on every byte; the byte marked last returns one result:
// the offset of the first OPT record, the offset past the last record, or a not-supported or
// malformed verdict with its reason. A single registered parse state is updated per byte,
// so a byte is accepted in every cycle while results are taken.
// One result register sits on the output; while a result waits to be taken the input stalls,
// and bytes flow again in the cycle the result is taken. The result is valid the cycle after
// the last byte is accepted.
module dns_message_opt_record_locator_unit
  import dnsopt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam logic [3:0] PhHeader = 4'd0;
  localparam logic [3:0] PhQLen   = 4'd1;
  localparam logic [3:0] PhQSkip  = 4'd2;
  localparam logic [3:0] PhQTail  = 4'd3;
  localparam logic [3:0] PhRLen   = 4'd4;
  localparam logic [3:0] PhRSkip  = 4'd5;
  localparam logic [3:0] PhPtr2   = 4'd6;
  localparam logic [3:0] PhRFix   = 4'd7;
  localparam logic [3:0] PhRData  = 4'd8;
  localparam logic [3:0] PhDone   = 4'd9;

  logic [15:0] pos_q, pos_d;
  logic [3:0]  phase_q, phase_d;
  logic [17:0] recs_q, recs_d;
  logic [8:0]  nlen_q, nlen_d;
  logic [15:0] skip_q, skip_d;
  logic [3:0]  fidx_q, fidx_d;
  logic [15:0] held_q, held_d;
  logic [15:0] rstart_q, rstart_d;
  out_t        outc_q, outc_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_data_q, out_data_d;

  logic        in_fire;
  logic [7:0]  b;
  logic [16:0] len17, p17, pnext17;
  logic [15:0] word;
  logic [9:0]  nl;
  logic        item_end;
  logic        is_rec;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign b          = in_data_i.payload_byte;
  assign len17      = {1'b0, in_data_i.message_length};
  assign p17        = {1'b0, pos_q};
  assign pnext17    = p17 + 17'd1;
  assign word       = {held_q[7:0], b};
  assign nl         = {1'b0, nlen_q} + {2'b0, b} + 10'd1;
  assign is_rec     = (phase_q == PhRLen);

  always_comb begin
    pos_d    = pos_q;
    phase_d  = phase_q;
    recs_d   = recs_q;
    nlen_d   = nlen_q;
    skip_d   = skip_q;
    fidx_d   = fidx_q;
    held_d   = held_q;
    rstart_d = rstart_q;
    outc_d   = outc_q;
    item_end = 1'b0;

    if (in_fire) begin
      pos_d = pnext17[15:0];
      unique case (phase_q)
        PhHeader: begin
          if (pos_q == 16'd0 && len17 < 17'(HeaderBytes)) begin
            outc_d  = '{VerdictMalformed, ReasonShort, 16'd0};
            phase_d = PhDone;
          end else if (pos_q == 16'd2) begin
            if (b[6:3] != 4'd0) begin
              outc_d  = '{VerdictUnsupport, ReasonOpcode, 16'd0};
              phase_d = PhDone;
            end else begin
              held_d = {b[7], 15'd0};
            end
          end else if (pos_q == 16'd4) begin
            held_d = {held_q[15], 7'd0, b};
          end else if (pos_q == 16'd5) begin
            if (word != 16'd1) begin
              outc_d  = '{VerdictUnsupport, ReasonQdCount, 16'd0};
              phase_d = PhDone;
            end else if (held_q[15] != in_data_i.direction) begin
              outc_d  = '{VerdictUnsupport, ReasonDirection, 16'd0};
              phase_d = PhDone;
            end else if (len17 < 17'(HeaderBytes + MinBody)) begin
              outc_d  = '{VerdictMalformed, ReasonShort, 16'd0};
              phase_d = PhDone;
            end
          end else if (pos_q == 16'd6 || pos_q == 16'd8 || pos_q == 16'd10) begin
            held_d = {8'd0, b};
          end else if (pos_q == 16'd7 || pos_q == 16'd9 || pos_q >= 16'd11) begin
            // accumulate answer, authority and additional counts
            recs_d = recs_q + {2'b0, word};
            if (pos_q >= 16'd11) begin
              nlen_d  = 9'd1;
              phase_d = PhQLen;
            end
          end
        end
        PhQLen, PhRLen: begin
          if (is_rec && b[7:6] == PtrBits) begin
            if (p17 + 17'(2 + FixedBytes) > len17) begin
              outc_d  = '{VerdictMalformed, ReasonShort, 16'd0};
              phase_d = PhDone;
            end else begin
              phase_d = PhPtr2;
            end
          end else if (b == 8'd0) begin
            if (!is_rec) begin
              if (p17 + 17'd5 > len17) begin
                outc_d  = '{VerdictMalformed, ReasonShort, 16'd0};
                phase_d = PhDone;
              end else begin
                fidx_d  = 4'd0;
                phase_d = PhQTail;
              end
            end else if (p17 + 17'(1 + FixedBytes) > len17) begin
              outc_d  = '{VerdictMalformed, ReasonShort, 16'd0};
              phase_d = PhDone;
            end else begin
              fidx_d  = 4'd0;
              phase_d = PhRFix;
            end
          end else begin
            if (b > 8'(MAX_LABEL_BYTES) || nl > 10'(MAX_NAME_BYTES)) begin
              outc_d  = '{VerdictMalformed, ReasonNameLen, 16'd0};
              phase_d = PhDone;
            end else if (p17 + {9'd0, b} + 17'd2 > len17) begin
              outc_d  = '{VerdictMalformed, ReasonShort, 16'd0};
              phase_d = PhDone;
            end else begin
              nlen_d  = nl[8:0];
              skip_d  = {8'd0, b};
              phase_d = is_rec ? PhRSkip : PhQSkip;
            end
          end
        end
        PhQSkip, PhRSkip: begin
          skip_d = skip_q - 16'd1;
          if (skip_q == 16'd1) begin
            phase_d = (phase_q == PhQSkip) ? PhQLen : PhRLen;
          end
        end
        PhQTail: begin
          if (fidx_q == 4'd2) begin
            held_d = {8'd0, b};
          end else if (fidx_q == 4'd3) begin
            if (word != ClassIn) begin
              outc_d  = '{VerdictUnsupport, ReasonClass, 16'd0};
              phase_d = PhDone;
            end else begin
              item_end = 1'b1;
            end
          end
          fidx_d = fidx_q + 4'd1;
        end
        PhPtr2: begin
          fidx_d  = 4'd0;
          phase_d = PhRFix;
        end
        PhRFix: begin
          if (fidx_q == 4'd0 || fidx_q == 4'd8) begin
            held_d = {8'd0, b};
          end else if (fidx_q == 4'd1) begin
            if (word == TypeOpt) begin
              outc_d  = '{VerdictOpt, ReasonNone, rstart_q};
              phase_d = PhDone;
            end
          end else if (fidx_q == 4'd9) begin
            if (pnext17 + {1'b0, word} > len17) begin
              outc_d  = '{VerdictMalformed, ReasonShort, 16'd0};
              phase_d = PhDone;
            end else if (word == 16'd0) begin
              item_end = 1'b1;
            end else begin
              skip_d  = word;
              phase_d = PhRData;
            end
          end
          fidx_d = fidx_q + 4'd1;
        end
        PhRData: begin
          skip_d = skip_q - 16'd1;
          if (skip_q == 16'd1) begin
            item_end = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // question tail or record finished: start the next record or close the message
      if (item_end) begin
        if (recs_q == 18'd0) begin
          outc_d  = '{VerdictParsed, ReasonNone, pnext17[15:0]};
          phase_d = PhDone;
        end else if (pnext17 >= len17) begin
          outc_d  = '{VerdictMalformed, ReasonShort, 16'd0};
          phase_d = PhDone;
        end else begin
          recs_d   = recs_q - 18'd1;
          rstart_d = pnext17[15:0];
          nlen_d   = 9'd1;
          phase_d  = PhRLen;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (in_fire && in_data_i.last_byte) begin
      out_valid_d = 1'b1;
      out_data_d  = (phase_d == PhDone) ? outc_d
                                        : '{VerdictMalformed, ReasonShort, 16'd0};
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      phase_q     <= PhHeader;
      recs_q      <= '0;
      nlen_q      <= 9'd1;
      skip_q      <= '0;
      fidx_q      <= '0;
      held_q      <= '0;
      rstart_q    <= '0;
      outc_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire && in_data_i.last_byte) begin
        // rearm for the next message
        pos_q    <= '0;
        phase_q  <= PhHeader;
        recs_q   <= '0;
        nlen_q   <= 9'd1;
        skip_q   <= '0;
        fidx_q   <= '0;
        held_q   <= '0;
        rstart_q <= '0;
        outc_q   <= '0;
      end else begin
        pos_q    <= pos_d;
        phase_q  <= phase_d;
        recs_q   <= recs_d;
        nlen_q   <= nlen_d;
        skip_q   <= skip_d;
        fidx_q   <= fidx_d;
        held_q   <= held_d;
        rstart_q <= rstart_d;
        outc_q   <= outc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/dnsopt_checker.sv
`timescale 1ns / 1ps

module dnsopt_checker
  import dnsopt_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // never stall the input while the result register is empty
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // a new result follows only a request carrying the last byte
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && in_data_i.last_byte))
    else $error("result without a last byte");

  // verdict, reason and offset agree
  a_verdict_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_data_o.verdict == VerdictParsed || out_data_o.verdict == VerdictOpt)
         && out_data_o.reason == ReasonNone)
      || (out_data_o.verdict == VerdictUnsupport && out_data_o.record_offset == 16'd0
         && (out_data_o.reason == ReasonOpcode || out_data_o.reason == ReasonQdCount
             || out_data_o.reason == ReasonDirection || out_data_o.reason == ReasonClass))
      || (out_data_o.verdict == VerdictMalformed && out_data_o.record_offset == 16'd0
         && (out_data_o.reason == ReasonShort || out_data_o.reason == ReasonNameLen)))
    else $error("inconsistent verdict");

endmodule

bind dns_message_opt_record_locator_unit dnsopt_checker u_dnsopt_checker (.*);
